>>> hdl/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and byte constants for the IRC message field splitter.
// ----------------------------------------------------------------------------
package ims_pkg;

    // Parse phase of the current message
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_TAGNAME = 4'd1,
        PH_TAGVAL  = 4'd2,
        PH_SRCPOS  = 4'd3,
        PH_SOURCE  = 4'd4,
        PH_CMDGAP  = 4'd5,
        PH_COMMAND = 4'd6,
        PH_PARAMS  = 4'd7,
        PH_TRAIL   = 4'd8,
        PH_DISCARD = 4'd9
    } t_phase;

    // Byte classification codes
    typedef enum logic [2:0] {
        K_DELIM  = 3'd0,
        K_TNAME  = 3'd1,
        K_TVAL   = 3'd2,
        K_SOURCE = 3'd3,
        K_CMD    = 3'd4,
        K_MIDDLE = 3'd5,
        K_TRAIL  = 3'd6,
        K_DROP   = 3'd7
    } t_kind;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    localparam logic TAGS_EN_RESET = 1'b1;

endpackage

>>> hdl/irc_message_field_splitter.sv
// ----------------------------------------------------------------------------
// irc_message_field_splitter
// Classifies each byte of an IRC line (IRCv3 tags, source, command, params)
// and flags field boundaries, message end and malformed messages.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+-------------------------------
// in       | in  | i_in_valid / o_in_stall    | i_line_byte
// out      | out | o_out_valid / i_out_stall  | o_data_byte, o_byte_kind,
//          |     |                            | o_starts_field, o_field_closed,
//          |     |                            | o_closed_kind, o_message_end,
//          |     |                            | o_malformed
// cfg      | in  | i_cfg_valid / o_cfg_ready  | i_tags_enabled
//
// One byte per cycle sustained while i_out_stall is low; a byte's result is
// offered once it has passed the input register, then the result register.
// The parse state updates as a byte moves from the input register to the
// result register, so consecutive bytes see each other's effect at once.
// i_out_stall holds the result register; o_in_stall rises only when both
// registers are full and the result is stalled.
// Reset (synchronous, active low) empties both stages and returns the parser
// to message start with tags enabled.
module irc_message_field_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ims_pkg::BYTE_W-1:0]  i_line_byte,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ims_pkg::BYTE_W-1:0]  o_data_byte,
    output logic [2:0]                  o_byte_kind,
    output logic                        o_starts_field,
    output logic                        o_field_closed,
    output logic [2:0]                  o_closed_kind,
    output logic                        o_message_end,
    output logic                        o_malformed,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_tags_enabled
);
    import ims_pkg::*;

    // handshake / stage registers
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    t_kind             r_kind;
    logic              r_start;
    logic              r_closed;
    t_kind             r_ckind;
    logic              r_end;
    logic              r_bad;
    logic              r_tags_en;

    // parser state
    t_phase r_phase;
    logic   r_has;
    logic   r_prev;
    logic   r_cr;

    t_phase n_phase;
    logic   n_has;
    logic   n_prev;
    logic   n_cr;

    // combinational result
    t_kind  n_kind;
    logic   n_start;
    logic   n_closed;
    t_kind  n_ckind;
    logic   n_end;
    logic   n_bad;

    logic   w_adv;
    logic   w_in_acc;
    logic   w_is_crlf;
    logic   w_is_lf;

    // pipeline control
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_is_lf   = (r_in_byte == CH_LF);
    assign w_is_crlf = (r_in_byte == CH_CR) || w_is_lf;

    // result classification of the byte in the input register
    always_comb begin
        n_kind   = K_DROP;
        n_start  = 1'b0;
        n_closed = 1'b0;
        n_ckind  = K_DELIM;
        n_end    = 1'b0;
        n_bad    = 1'b0;
        case (r_phase)
            PH_START, PH_SRCPOS: begin
                if (r_phase == PH_START && r_in_byte == CH_AT) begin
                    if (r_tags_en) begin
                        n_kind = K_DELIM;
                    end else begin
                        n_bad = 1'b1;
                    end
                end else if (r_in_byte == CH_SPACE || r_in_byte == CH_COLON) begin
                    n_kind = K_DELIM;
                end else if (w_is_crlf) begin
                    n_bad = 1'b1;
                end else begin
                    n_kind  = K_CMD;
                    n_start = 1'b1;
                end
            end
            PH_TAGNAME, PH_TAGVAL: begin
                if (w_is_crlf || r_in_byte == CH_NUL) begin
                    n_bad = 1'b1;
                end else if (r_in_byte == CH_SEMI || r_in_byte == CH_SPACE
                             || (r_in_byte == CH_EQ && r_phase == PH_TAGNAME)) begin
                    n_kind   = K_DELIM;
                    n_closed = 1'b1;
                    n_ckind  = (r_phase == PH_TAGNAME) ? K_TNAME : K_TVAL;
                end else begin
                    n_kind  = (r_phase == PH_TAGNAME) ? K_TNAME : K_TVAL;
                    n_start = !r_has;
                end
            end
            PH_SOURCE: begin
                if (r_in_byte == CH_SPACE) begin
                    n_kind   = K_DELIM;
                    n_closed = 1'b1;
                    n_ckind  = K_SOURCE;
                end else if (w_is_crlf) begin
                    n_bad = 1'b1;
                end else begin
                    n_kind  = K_SOURCE;
                    n_start = !r_has;
                end
            end
            PH_CMDGAP: begin
                if (r_in_byte == CH_SPACE) begin
                    n_kind = K_DELIM;
                end else if (w_is_crlf) begin
                    n_bad = 1'b1;
                end else begin
                    n_kind  = K_CMD;
                    n_start = 1'b1;
                end
            end
            PH_COMMAND: begin
                if (r_in_byte == CH_SPACE || r_in_byte == CH_CR) begin
                    n_kind   = K_DELIM;
                    n_closed = 1'b1;
                    n_ckind  = K_CMD;
                end else if (w_is_lf) begin
                    n_bad = 1'b1;
                end else begin
                    n_kind  = K_CMD;
                    n_start = !r_has;
                end
            end
            PH_PARAMS, PH_TRAIL: begin
                if (r_cr) begin
                    // only LF may follow CR
                    if (w_is_lf) begin
                        n_kind   = K_DELIM;
                        n_end    = 1'b1;
                        n_closed = (r_phase == PH_TRAIL) || r_has;
                        if (r_phase == PH_TRAIL) begin
                            n_ckind = K_TRAIL;
                        end else if (r_has) begin
                            n_ckind = K_MIDDLE;
                        end
                    end else begin
                        n_bad = 1'b1;
                    end
                end else if (r_in_byte == CH_CR) begin
                    n_kind = K_DELIM;
                end else if (w_is_lf) begin
                    n_bad = 1'b1;
                end else if (r_phase == PH_TRAIL) begin
                    n_kind  = K_TRAIL;
                    n_start = !r_has;
                end else if (r_in_byte == CH_SPACE) begin
                    n_kind   = K_DELIM;
                    n_closed = r_has;
                    n_ckind  = r_has ? K_MIDDLE : K_DELIM;
                end else if (r_in_byte == CH_COLON && r_prev && !r_has) begin
                    n_kind = K_DELIM;
                end else begin
                    n_kind  = K_MIDDLE;
                    n_start = !r_has;
                end
            end
            default: begin
                n_kind = K_DROP;
            end
        endcase
    end

    // next parser state
    always_comb begin
        n_phase = r_phase;
        n_has   = r_has;
        n_prev  = r_prev;
        n_cr    = r_cr;
        if (n_bad) begin
            n_phase = w_is_lf ? PH_START : PH_DISCARD;
            n_has   = 1'b0;
            n_prev  = 1'b0;
            n_cr    = 1'b0;
        end else begin
            case (r_phase)
                PH_START, PH_SRCPOS: begin
                    if (r_phase == PH_START && r_in_byte == CH_AT) begin
                        n_phase = PH_TAGNAME;
                        n_has   = 1'b0;
                    end else if (r_in_byte == CH_SPACE) begin
                        n_phase = PH_SRCPOS;
                    end else if (r_in_byte == CH_COLON) begin
                        n_phase = PH_SOURCE;
                        n_has   = 1'b0;
                    end else begin
                        n_phase = PH_COMMAND;
                        n_has   = 1'b1;
                    end
                end
                PH_TAGNAME, PH_TAGVAL: begin
                    if (r_in_byte == CH_SEMI) begin
                        n_phase = PH_TAGNAME;
                        n_has   = 1'b0;
                    end else if (r_in_byte == CH_SPACE) begin
                        n_phase = PH_SRCPOS;
                        n_has   = 1'b0;
                    end else if (r_in_byte == CH_EQ && r_phase == PH_TAGNAME) begin
                        n_phase = PH_TAGVAL;
                        n_has   = 1'b0;
                    end else begin
                        n_has = 1'b1;
                    end
                end
                PH_SOURCE: begin
                    if (r_in_byte == CH_SPACE) begin
                        n_phase = PH_CMDGAP;
                        n_has   = 1'b0;
                    end else begin
                        n_has = 1'b1;
                    end
                end
                PH_CMDGAP: begin
                    if (r_in_byte != CH_SPACE) begin
                        n_phase = PH_COMMAND;
                        n_has   = 1'b1;
                    end
                end
                PH_COMMAND: begin
                    if (r_in_byte == CH_SPACE) begin
                        n_phase = PH_PARAMS;
                        n_has   = 1'b0;
                        n_prev  = 1'b1;
                        n_cr    = 1'b0;
                    end else if (r_in_byte == CH_CR) begin
                        n_phase = PH_PARAMS;
                        n_has   = 1'b0;
                        n_prev  = 1'b0;
                        n_cr    = 1'b1;
                    end else begin
                        n_has = 1'b1;
                    end
                end
                PH_PARAMS, PH_TRAIL: begin
                    if (r_cr) begin
                        // LF after CR: message complete
                        n_phase = PH_START;
                        n_has   = 1'b0;
                        n_prev  = 1'b0;
                        n_cr    = 1'b0;
                    end else if (r_in_byte == CH_CR) begin
                        n_cr = 1'b1;
                    end else if (r_phase == PH_TRAIL) begin
                        n_has = 1'b1;
                    end else if (r_in_byte == CH_SPACE) begin
                        n_has  = 1'b0;
                        n_prev = 1'b1;
                    end else if (r_in_byte == CH_COLON && r_prev && !r_has) begin
                        n_phase = PH_TRAIL;
                        n_has   = 1'b0;
                        n_prev  = 1'b0;
                    end else begin
                        n_has  = 1'b1;
                        n_prev = 1'b0;
                    end
                end
                default: begin
                    if (w_is_lf) begin
                        n_phase = PH_START;
                        n_has   = 1'b0;
                        n_prev  = 1'b0;
                        n_cr    = 1'b0;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tags_en   <= TAGS_EN_RESET;
            r_phase     <= PH_START;
            r_has       <= 1'b0;
            r_prev      <= 1'b0;
            r_cr        <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tags_en <= i_tags_enabled;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_has   <= n_has;
                r_prev  <= n_prev;
                r_cr    <= n_cr;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_line_byte;
        end
        if (w_adv) begin
            r_out_byte <= r_in_byte;
            r_kind     <= n_kind;
            r_start    <= n_start;
            r_closed   <= n_closed;
            r_ckind    <= n_ckind;
            r_end      <= n_end;
            r_bad      <= n_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_byte    = r_out_byte;
    assign o_byte_kind    = r_kind;
    assign o_starts_field = r_start;
    assign o_field_closed = r_closed;
    assign o_closed_kind  = r_ckind;
    assign o_message_end  = r_end;
    assign o_malformed    = r_bad;

endmodule
